// ===== rtl/i2crts_pkg.sv =====
package i2crts_pkg;

    localparam int unsigned MAX_LENGTH = 255;
    localparam logic [15:0] MAX_LENGTH_W = 16'(MAX_LENGTH);

    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd1;
    localparam logic [15:0] WAIT_LIMIT_RST  = 16'd1000;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_WDATA  = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RXACK = 3'd3,
        ACT_RXNAK = 3'd4,
        ACT_STOP  = 3'd5
    } t_action;

    localparam logic [3:0] ST_START      = 4'd0;
    localparam logic [3:0] ST_REP_START  = 4'd1;
    localparam logic [3:0] ST_WSLA_ACK   = 4'd2;
    localparam logic [3:0] ST_WSLA_NACK  = 4'd3;
    localparam logic [3:0] ST_WDATA_ACK  = 4'd4;
    localparam logic [3:0] ST_WDATA_NACK = 4'd5;
    localparam logic [3:0] ST_ARB_LOST   = 4'd6;
    localparam logic [3:0] ST_RSLA_ACK   = 4'd7;
    localparam logic [3:0] ST_RSLA_NACK  = 4'd8;
    localparam logic [3:0] ST_RDATA_ACK  = 4'd9;
    localparam logic [3:0] ST_RDATA_NACK = 4'd10;

    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_WAIT_LIMIT  = 1'b1;

    typedef struct packed {
        t_action    action;
        logic [7:0] byte_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_data;
        logic       done_res;
        logic       failed;
        logic [7:0] byte_count;
    } t_result;

endpackage

// ===== rtl/i2c_register_transfer_sequencer.sv =====
// Channel     | Dir | Handshake               | Payload
// ------------+-----+-------------------------+--------------------------------------
// s_axis      | in  | i_s_axis_tvalid/tready  | tuser kind, tdata request/status/data
// m_axis      | out | o_m_axis_tvalid/tready  | tdata bus command and transfer result
// cfg         | in  | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Every input beat produces exactly one result beat, registered and shown in the cycle after the beat is taken.
// The sequencer state and the result register update in the same cycle.
// A new beat is taken each cycle while the result register is empty or being drained.
// A stall on the output holds the result and blocks input until it is taken.
// Reset clears the sequencer state and loads retry_limit 1 and wait_limit 1000.
module i2c_register_transfer_sequencer
    import i2crts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] is_read, [8:1] device_base, [16:9] register_address, [24:17] length,
    // [28:25] bus_status, [36:29] rx_byte, [44:37] tx_byte, [47:45] zero
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] action, [10:3] byte_out, [18:11] read_byte, [19] read_valid,
    // [20] want_data, [21] done_res, [22] failed, [30:23] byte_count, [31] zero
    output logic [31:0] o_m_axis_tdata,

    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_WSLA   = 4'd2,
        PH_REG    = 4'd3,
        PH_WDREQ  = 4'd4,
        PH_WDATA  = 4'd5,
        PH_RSTART = 4'd6,
        PH_RSLA   = 4'd7,
        PH_RDATA  = 4'd8
    } t_phase;

    logic [7:0]  r_retry_limit;
    logic [15:0] r_wait_limit;

    t_phase      r_phase,        n_phase;
    logic        r_read_mode,    n_read_mode;
    logic [7:0]  r_device,       n_device;
    logic [7:0]  r_register,     n_register;
    logic [7:0]  r_remaining,    n_remaining;
    logic [7:0]  r_transferred,  n_transferred;
    logic [7:0]  r_retries,      n_retries;
    logic [15:0] r_wait_count,   n_wait_count;

    logic        r_out_valid;
    t_result     r_res,          n_res;

    logic        in_accept;
    logic        waiting;
    t_kind       kind;
    logic        is_read;
    logic [7:0]  device_base;
    logic [7:0]  register_address;
    logic [7:0]  length;
    logic [3:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
    logic [7:0]  len_sat;
    logic [15:0] wc_inc;
    logic [7:0]  rem_dec;

    assign kind             = t_kind'(i_s_axis_tuser);
    assign is_read          = i_s_axis_tdata[0];
    assign device_base      = i_s_axis_tdata[8:1];
    assign register_address = i_s_axis_tdata[16:9];
    assign length           = i_s_axis_tdata[24:17];
    assign bus_status       = i_s_axis_tdata[28:25];
    assign rx_byte          = i_s_axis_tdata[36:29];
    assign tx_byte          = i_s_axis_tdata[44:37];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign waiting         = (r_phase != PH_IDLE) && (r_phase != PH_WDREQ);
    assign len_sat         = ({8'd0, length} > MAX_LENGTH_W) ? MAX_LENGTH_W[7:0] : length;
    assign wc_inc          = r_wait_count + 16'd1;
    assign rem_dec         = r_remaining - 8'd1;

    always_comb begin
        n_phase       = r_phase;
        n_read_mode   = r_read_mode;
        n_device      = r_device;
        n_register    = r_register;
        n_remaining   = r_remaining;
        n_transferred = r_transferred;
        n_retries     = r_retries;
        n_wait_count  = r_wait_count;
        n_res         = '0;
        n_res.action  = ACT_NONE;

        unique case (kind)
            KIND_START: begin
                if (r_phase == PH_IDLE) begin
                    n_read_mode   = is_read;
                    n_device      = {device_base[7:1], 1'b0};
                    n_register    = register_address;
                    n_remaining   = len_sat;
                    n_transferred = '0;
                    n_wait_count  = '0;
                    if (r_retry_limit == 8'd0) begin
                        n_res.done_res = 1'b1;
                        n_res.failed   = 1'b1;
                        n_retries      = '0;
                    end else begin
                        n_retries    = 8'd1;
                        n_res.action = ACT_START;
                        n_phase      = PH_START;
                    end
                end
            end
            KIND_STATUS: begin
                if (waiting) begin
                    n_wait_count = '0;
                    // Default for an unexpected status: stop and fail.
                    n_res.action   = ACT_STOP;
                    n_res.done_res = 1'b1;
                    n_res.failed   = 1'b1;
                    n_phase        = PH_IDLE;
                    unique case (r_phase)
                        PH_START: begin
                            if (bus_status == ST_START || bus_status == ST_REP_START) begin
                                n_res          = '0;
                                n_res.action   = ACT_SEND;
                                n_res.byte_out = r_device;
                                n_phase        = PH_WSLA;
                            end else if (bus_status == ST_ARB_LOST) begin
                                n_res        = '0;
                                n_res.action = ACT_START;
                                n_phase      = PH_START;
                            end else begin
                                n_res.action = ACT_NONE;
                            end
                        end
                        PH_WSLA: begin
                            if (bus_status == ST_WSLA_ACK) begin
                                n_res          = '0;
                                n_res.action   = ACT_SEND;
                                n_res.byte_out = r_register;
                                n_phase        = PH_REG;
                            end else if (bus_status == ST_WSLA_NACK) begin
                                if (r_retries >= r_retry_limit) begin
                                    n_res.action = ACT_NONE;
                                end else begin
                                    n_retries    = r_retries + 8'd1;
                                    n_res        = '0;
                                    n_res.action = ACT_START;
                                    n_phase      = PH_START;
                                end
                            end else if (bus_status == ST_ARB_LOST) begin
                                n_res        = '0;
                                n_res.action = ACT_START;
                                n_phase      = PH_START;
                            end
                        end
                        PH_REG: begin
                            if (bus_status == ST_WDATA_ACK) begin
                                if (r_read_mode) begin
                                    n_res        = '0;
                                    n_res.action = ACT_START;
                                    n_phase      = PH_RSTART;
                                end else if (r_remaining != 8'd0) begin
                                    n_res           = '0;
                                    n_res.action    = ACT_NONE;
                                    n_res.want_data = 1'b1;
                                    n_phase         = PH_WDREQ;
                                end else begin
                                    n_res.failed = 1'b0;
                                end
                            end else if (bus_status == ST_WDATA_NACK) begin
                                n_res.failed = 1'b0;
                            end else if (bus_status == ST_ARB_LOST) begin
                                n_res        = '0;
                                n_res.action = ACT_START;
                                n_phase      = PH_START;
                            end
                        end
                        PH_WDATA: begin
                            if (bus_status == ST_WDATA_ACK) begin
                                n_transferred = r_transferred + 8'd1;
                                n_remaining   = rem_dec;
                                if (rem_dec != 8'd0) begin
                                    n_res           = '0;
                                    n_res.action    = ACT_NONE;
                                    n_res.want_data = 1'b1;
                                    n_phase         = PH_WDREQ;
                                end else begin
                                    n_res.failed = 1'b0;
                                end
                            end
                        end
                        PH_RSTART: begin
                            if (bus_status == ST_START || bus_status == ST_REP_START) begin
                                n_res          = '0;
                                n_res.action   = ACT_SEND;
                                n_res.byte_out = {r_device[7:1], 1'b1};
                                n_phase        = PH_RSLA;
                            end else if (bus_status == ST_ARB_LOST) begin
                                n_res        = '0;
                                n_res.action = ACT_START;
                                n_phase      = PH_START;
                            end
                        end
                        PH_RSLA: begin
                            if (bus_status == ST_RSLA_ACK) begin
                                if (r_remaining != 8'd0) begin
                                    n_res        = '0;
                                    n_res.action = (r_remaining == 8'd1) ? ACT_RXNAK
                                                                         : ACT_RXACK;
                                    n_phase      = PH_RDATA;
                                end else begin
                                    n_res.failed = 1'b0;
                                end
                            end else if (bus_status == ST_RSLA_NACK) begin
                                n_res.failed = 1'b0;
                            end else if (bus_status == ST_ARB_LOST) begin
                                n_res        = '0;
                                n_res.action = ACT_START;
                                n_phase      = PH_START;
                            end
                        end
                        PH_RDATA: begin
                            if (bus_status == ST_RDATA_ACK || bus_status == ST_RDATA_NACK) begin
                                n_transferred = r_transferred + 8'd1;
                                n_remaining   = (bus_status == ST_RDATA_NACK) ? 8'd0 : rem_dec;
                                if (bus_status != ST_RDATA_NACK && rem_dec != 8'd0) begin
                                    n_res        = '0;
                                    n_res.action = (rem_dec == 8'd1) ? ACT_RXNAK : ACT_RXACK;
                                    n_phase      = PH_RDATA;
                                end else begin
                                    n_res.failed = 1'b0;
                                end
                                n_res.read_byte  = rx_byte;
                                n_res.read_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            KIND_WDATA: begin
                if (r_phase == PH_WDREQ) begin
                    n_res.action   = ACT_SEND;
                    n_res.byte_out = tx_byte;
                    n_phase        = PH_WDATA;
                    n_wait_count   = '0;
                end
            end
            KIND_TICK: begin
                if (waiting) begin
                    if (wc_inc >= r_wait_limit || wc_inc == 16'd0) begin
                        n_res.done_res = 1'b1;
                        n_res.failed   = 1'b1;
                        n_phase        = PH_IDLE;
                        n_wait_count   = '0;
                    end else begin
                        n_wait_count = wc_inc;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        n_res.byte_count = n_transferred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RST;
            r_wait_limit  <= WAIT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[7:0];
                CFG_WAIT_LIMIT:  r_wait_limit  <= i_cfg_data;
                default:         r_wait_limit  <= r_wait_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_read_mode   <= 1'b0;
            r_device      <= '0;
            r_register    <= '0;
            r_remaining   <= '0;
            r_transferred <= '0;
            r_retries     <= '0;
            r_wait_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase       <= n_phase;
                r_read_mode   <= n_read_mode;
                r_device      <= n_device;
                r_register    <= n_register;
                r_remaining   <= n_remaining;
                r_transferred <= n_transferred;
                r_retries     <= n_retries;
                r_wait_count  <= n_wait_count;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_res.byte_count, r_res.failed, r_res.done_res,
                              r_res.want_data, r_res.read_valid, r_res.read_byte,
                              r_res.byte_out, r_res.action};

`ifndef SYNTH
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_res.done_res |=> r_phase == PH_IDLE)
        else $error("finished transfer did not return to idle");

    a_fail_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.failed |-> r_res.done_res)
        else $error("failure flagged without transfer end");

    a_want_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_res.want_data |=> r_phase == PH_WDREQ)
        else $error("data request issued outside write data wait");

    a_read_from_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_res.read_valid |-> r_phase == PH_RDATA)
        else $error("read byte delivered outside read data phase");
`endif

endmodule

// ===== dv/tb_i2c_register_transfer_sequencer.sv =====
module tb_i2c_register_transfer_sequencer;
    import i2crts_pkg::*;

    typedef struct {
        t_kind      kind;
        logic       is_read;
        logic [7:0] device_base;
        logic [7:0] register_address;
        logic [7:0] length;
        logic [3:0] bus_status;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_beat;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START, SQ_WSLA, SQ_REG, SQ_WDREQ, SQ_WDATA, SQ_RSTART, SQ_RSLA, SQ_RDATA
    } t_seq_phase;

    typedef enum logic [2:0] {
        W_START, W_WSLA, W_REG, W_RSTART, W_RSLA, W_WDATA, W_RDATA, W_DONE
    } t_walk_stage;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [0] is_read, [8:1] device_base, [16:9] register_address, [24:17] length,
    // [28:25] bus_status, [36:29] rx_byte, [44:37] tx_byte, [47:45] zero
    logic [47:0] i_s_axis_tdata = '0;
    // [1:0] kind
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [2:0] action, [10:3] byte_out, [18:11] read_byte, [19] read_valid,
    // [20] want_data, [21] done_res, [22] failed, [30:23] byte_count, [31] zero
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;

    i2c_register_transfer_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    t_beat   pending_beats [$];
    t_result expected_results [$];

    t_seq_phase  sq_phase = SQ_IDLE;
    logic        sq_read = 1'b0;
    logic [7:0]  sq_device = '0;
    logic [7:0]  sq_register = '0;
    logic [7:0]  sq_remaining = '0;
    logic [7:0]  sq_count = '0;
    logic [7:0]  sq_retries = '0;
    logic [15:0] sq_wait = '0;
    logic [7:0]  lim_retry = RETRY_LIMIT_RST;
    logic [15:0] lim_wait = WAIT_LIMIT_RST;
    t_result     nxt;

    int unsigned acted_beats = 0;
    int unsigned beats_taken = 0;
    int unsigned results_checked = 0;
    int unsigned n_done_ok = 0;
    int unsigned n_failed = 0;
    int unsigned n_bytes_read = 0;
    int unsigned n_bytes_written = 0;
    int unsigned settings_used = 0;
    int unsigned mismatches = 0;

    function automatic void seq_cmd(t_action act, logic [7:0] data, t_seq_phase ph);
        nxt.action = act;
        nxt.byte_out = data;
        sq_phase = ph;
        sq_wait = '0;
    endfunction

    function automatic void seq_close(logic fail, logic stop);
        nxt.action = stop ? ACT_STOP : ACT_NONE;
        nxt.done_res = 1'b1;
        nxt.failed = fail;
        sq_phase = SQ_IDLE;
        sq_wait = '0;
        if (fail) n_failed++;
        else n_done_ok++;
    endfunction

    function automatic void seq_attempt();
        if (sq_retries >= lim_retry) begin
            seq_close(1'b1, 1'b0);
        end else begin
            sq_retries++;
            seq_cmd(ACT_START, 8'h00, SQ_START);
        end
    endfunction

    function automatic void seq_want_data();
        nxt.want_data = 1'b1;
        sq_phase = SQ_WDREQ;
        sq_wait = '0;
    endfunction

    function automatic void seq_receive();
        seq_cmd((sq_remaining == 8'd1) ? ACT_RXNAK : ACT_RXACK, 8'h00, SQ_RDATA);
    endfunction

    function automatic void predict_beat(t_beat b);
        logic       waiting;
        logic [3:0] st;
        nxt = '0;
        st = b.bus_status;
        waiting = (sq_phase != SQ_IDLE) && (sq_phase != SQ_WDREQ);
        case (b.kind)
            KIND_START: begin
                if (sq_phase == SQ_IDLE) begin
                    acted_beats++;
                    sq_read = b.is_read;
                    sq_device = {b.device_base[7:1], 1'b0};
                    sq_register = b.register_address;
                    sq_remaining = (int'(b.length) > MAX_LENGTH) ? 8'(MAX_LENGTH) : b.length;
                    sq_count = '0;
                    sq_retries = '0;
                    seq_attempt();
                end
            end
            KIND_STATUS: begin
                if (waiting) begin
                    acted_beats++;
                    case (sq_phase)
                        SQ_START: begin
                            if (st == ST_START || st == ST_REP_START) begin
                                seq_cmd(ACT_SEND, sq_device, SQ_WSLA);
                            end else if (st == ST_ARB_LOST) begin
                                seq_cmd(ACT_START, 8'h00, SQ_START);
                            end else begin
                                seq_close(1'b1, 1'b0);
                            end
                        end
                        SQ_WSLA: begin
                            if (st == ST_WSLA_ACK) seq_cmd(ACT_SEND, sq_register, SQ_REG);
                            else if (st == ST_WSLA_NACK) seq_attempt();
                            else if (st == ST_ARB_LOST) seq_cmd(ACT_START, 8'h00, SQ_START);
                            else seq_close(1'b1, 1'b1);
                        end
                        SQ_REG: begin
                            if (st == ST_WDATA_ACK) begin
                                if (sq_read) seq_cmd(ACT_START, 8'h00, SQ_RSTART);
                                else if (sq_remaining != 0) seq_want_data();
                                else seq_close(1'b0, 1'b1);
                            end else if (st == ST_WDATA_NACK) begin
                                seq_close(1'b0, 1'b1);
                            end else if (st == ST_ARB_LOST) begin
                                seq_cmd(ACT_START, 8'h00, SQ_START);
                            end else begin
                                seq_close(1'b1, 1'b1);
                            end
                        end
                        SQ_WDATA: begin
                            if (st == ST_WDATA_ACK) begin
                                sq_count++;
                                n_bytes_written++;
                                sq_remaining--;
                                if (sq_remaining != 0) seq_want_data();
                                else seq_close(1'b0, 1'b1);
                            end else begin
                                seq_close(1'b1, 1'b1);
                            end
                        end
                        SQ_RSTART: begin
                            if (st == ST_START || st == ST_REP_START) begin
                                seq_cmd(ACT_SEND, sq_device | 8'h01, SQ_RSLA);
                            end else if (st == ST_ARB_LOST) begin
                                seq_cmd(ACT_START, 8'h00, SQ_START);
                            end else begin
                                seq_close(1'b1, 1'b1);
                            end
                        end
                        SQ_RSLA: begin
                            if (st == ST_RSLA_ACK) begin
                                if (sq_remaining != 0) seq_receive();
                                else seq_close(1'b0, 1'b1);
                            end else if (st == ST_RSLA_NACK) begin
                                seq_close(1'b0, 1'b1);
                            end else if (st == ST_ARB_LOST) begin
                                seq_cmd(ACT_START, 8'h00, SQ_START);
                            end else begin
                                seq_close(1'b1, 1'b1);
                            end
                        end
                        SQ_RDATA: begin
                            if (st == ST_RDATA_ACK || st == ST_RDATA_NACK) begin
                                nxt.read_byte = b.rx_byte;
                                nxt.read_valid = 1'b1;
                                sq_count++;
                                n_bytes_read++;
                                sq_remaining = (st == ST_RDATA_NACK) ? 8'd0 : sq_remaining - 8'd1;
                                if (sq_remaining != 0) seq_receive();
                                else seq_close(1'b0, 1'b1);
                            end else begin
                                seq_close(1'b1, 1'b1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            KIND_WDATA: begin
                if (sq_phase == SQ_WDREQ) begin
                    acted_beats++;
                    seq_cmd(ACT_SEND, b.tx_byte, SQ_WDATA);
                end
            end
            default: begin
                if (waiting) begin
                    acted_beats++;
                    sq_wait++;
                    if (sq_wait >= lim_wait || sq_wait == 16'd0) seq_close(1'b1, 1'b0);
                end
            end
        endcase
        nxt.byte_count = sq_count;
        expected_results.push_back(nxt);
    endfunction

    function automatic t_beat any_beat(t_kind k);
        t_beat b;
        b.kind = k;
        b.is_read = 1'($urandom);
        b.device_base = 8'($urandom);
        b.register_address = 8'($urandom);
        b.length = 8'($urandom);
        b.bus_status = 4'($urandom);
        b.rx_byte = 8'($urandom);
        b.tx_byte = 8'($urandom);
        return b;
    endfunction

    function automatic void queue_start(logic rd, logic [7:0] dev_byte, logic [7:0] reg_byte,
                                        logic [7:0] len_byte);
        t_beat b;
        b = any_beat(KIND_START);
        b.is_read = rd;
        b.device_base = dev_byte;
        b.register_address = reg_byte;
        b.length = len_byte;
        pending_beats.push_back(b);
    endfunction

    function automatic void queue_status(logic [3:0] st, logic [7:0] rx);
        t_beat b;
        b = any_beat(KIND_STATUS);
        b.bus_status = st;
        b.rx_byte = rx;
        pending_beats.push_back(b);
    endfunction

    function automatic void queue_wdata(logic [7:0] tx);
        t_beat b;
        b = any_beat(KIND_WDATA);
        b.tx_byte = tx;
        pending_beats.push_back(b);
    endfunction

    function automatic void queue_tick();
        pending_beats.push_back(any_beat(KIND_TICK));
    endfunction

    // One register transfer as the bus engine would report it, with arbitration
    // losses, address NACKs, early NACKs, stray ticks and corrupt statuses mixed in.
    function automatic void queue_transfer();
        logic        rd;
        int unsigned len, sent, guard, roll, corrupt_pct, data_err;
        t_walk_stage stage;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) pending_beats.push_back(any_beat(t_kind'($urandom_range(0, 3))));
        end
        rd = 1'($urandom);
        len = ($urandom_range(0, 79) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
        corrupt_pct = (len > 4) ? 0 : 3;
        data_err = (len > 4) ? 4 : 10;
        queue_start(rd, 8'($urandom), 8'($urandom), 8'(len));
        stage = W_START;
        sent = 0;
        guard = 0;
        while (stage != W_DONE && guard < 800) begin
            guard++;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) queue_tick();
            roll = $urandom_range(0, 99);
            if (roll < corrupt_pct) begin
                queue_status(4'($urandom), 8'($urandom));
            end else if (roll < 7 && stage <= W_RSLA) begin
                queue_status(ST_ARB_LOST, 8'($urandom));
                stage = W_START;
            end else begin
                case (stage)
                    W_START, W_RSTART: begin
                        queue_status($urandom_range(0, 1) ? ST_START : ST_REP_START, 8'($urandom));
                        stage = (stage == W_START) ? W_WSLA : W_RSLA;
                    end
                    W_WSLA: begin
                        if (roll < 15) begin
                            queue_status(ST_WSLA_NACK, 8'($urandom));
                            stage = W_START;
                        end else begin
                            queue_status(ST_WSLA_ACK, 8'($urandom));
                            stage = W_REG;
                        end
                    end
                    W_REG: begin
                        if (roll < 12) begin
                            queue_status(ST_WDATA_NACK, 8'($urandom));
                            stage = W_DONE;
                        end else begin
                            queue_status(ST_WDATA_ACK, 8'($urandom));
                            stage = rd ? W_RSTART : ((len == 0) ? W_DONE : W_WDATA);
                        end
                    end
                    W_RSLA: begin
                        if (roll < 12) begin
                            queue_status(ST_RSLA_NACK, 8'($urandom));
                            stage = W_DONE;
                        end else begin
                            queue_status(ST_RSLA_ACK, 8'($urandom));
                            stage = (len == 0) ? W_DONE : W_RDATA;
                        end
                    end
                    W_WDATA: begin
                        queue_wdata(8'($urandom));
                        queue_status((roll < data_err) ? ST_WDATA_NACK : ST_WDATA_ACK, 8'($urandom));
                        sent++;
                        if (roll < data_err || sent == len) stage = W_DONE;
                    end
                    W_RDATA: begin
                        queue_status((roll < data_err || sent + 1 == len) ? ST_RDATA_NACK
                                                                          : ST_RDATA_ACK,
                                     8'($urandom));
                        sent++;
                        if (roll < data_err || sent == len) stage = W_DONE;
                    end
                    default: stage = W_DONE;
                endcase
            end
        end
    endfunction

    t_beat       beat_on_bus;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                beats_taken++;
                predict_beat(beat_on_bus);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left != 0 || pending_beats.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    beat_on_bus = pending_beats.pop_front();
                    i_s_axis_tdata <= {3'b000, beat_on_bus.tx_byte, beat_on_bus.rx_byte,
                                       beat_on_bus.bus_status, beat_on_bus.length,
                                       beat_on_bus.register_address, beat_on_bus.device_base,
                                       beat_on_bus.is_read};
                    i_s_axis_tuser <= beat_on_bus.kind;
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    string       field_names [8] = '{"action", "byte_out", "read_byte", "read_valid",
                                     "want_data", "done_res", "failed", "byte_count"};
    t_result     want;
    logic [7:0]  got_fields [8];
    logic [7:0]  want_fields [8];
    int unsigned stall_mode = 0;
    int unsigned stall_timer = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat %h arrived with nothing expected", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                got_fields = '{8'(o_m_axis_tdata[2:0]), o_m_axis_tdata[10:3],
                               o_m_axis_tdata[18:11], 8'(o_m_axis_tdata[19]),
                               8'(o_m_axis_tdata[20]), 8'(o_m_axis_tdata[21]),
                               8'(o_m_axis_tdata[22]), o_m_axis_tdata[30:23]};
                want_fields = '{8'(want.action), want.byte_out, want.read_byte,
                                8'(want.read_valid), 8'(want.want_data), 8'(want.done_res),
                                8'(want.failed), want.byte_count};
                foreach (got_fields[f]) begin
                    if (got_fields[f] !== want_fields[f]) begin
                        $error("%s: expected %0d, actual %0d", field_names[f], want_fields[f],
                               got_fields[f]);
                        mismatches++;
                    end
                end
            end
        end
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(16, 96);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 2) != 0);
            2: i_m_axis_tready <= stall_timer[2];
            default: i_m_axis_tready <= (stall_timer % 5 == 0);
        endcase
    end

    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == CFG_RETRY_LIMIT) lim_retry = value[7:0];
        else lim_wait = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
    endtask

    logic [7:0]  plan_retry [7] = '{8'd3, 8'd255, 8'd1, 8'd2, 8'd255, 8'd1, 8'd8};
    logic [15:0] plan_wait [7] = '{16'd12, 16'd65535, 16'd1, 16'd3, 16'd2, 16'd65535, 16'd6};

    initial begin
        int unsigned plan;
        int unsigned beat_target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limits: ignored beats, a full write with an arbitration loss,
        // a two-byte read, and an address NACK with the single allowed attempt.
        queue_status(4'hF, 8'hFF);
        queue_tick();
        queue_wdata(8'hFF);
        queue_start(1'b0, 8'hFF, 8'h00, 8'd1);
        queue_start(1'b1, 8'h00, 8'hFF, 8'hFF);
        queue_tick();
        queue_status(ST_START, 8'h00);
        queue_status(ST_ARB_LOST, 8'h00);
        queue_status(ST_REP_START, 8'hFF);
        queue_status(ST_WSLA_ACK, 8'h00);
        queue_status(ST_WDATA_ACK, 8'h00);
        queue_status(ST_WDATA_ACK, 8'h00);
        queue_wdata(8'h5A);
        queue_status(ST_WDATA_ACK, 8'h00);
        queue_start(1'b1, 8'h00, 8'hFF, 8'd2);
        queue_status(ST_START, 8'h00);
        queue_status(ST_WSLA_ACK, 8'h00);
        queue_status(ST_WDATA_ACK, 8'h00);
        queue_status(ST_REP_START, 8'h00);
        queue_status(ST_RSLA_ACK, 8'h00);
        queue_status(ST_RDATA_ACK, 8'hFF);
        queue_status(ST_RDATA_NACK, 8'h00);
        queue_start(1'b0, 8'h3C, 8'h81, 8'd0);
        queue_status(ST_START, 8'h00);
        queue_status(ST_WSLA_NACK, 8'h00);
        wait_drained();
        settings_used++;

        // A zero retry limit refuses the start; a zero wait limit fails on the first tick.
        write_reg(CFG_RETRY_LIMIT, 16'd0);
        write_reg(CFG_WAIT_LIMIT, 16'd0);
        queue_start(1'b0, 8'h42, 8'h10, 8'd3);
        wait_drained();
        write_reg(CFG_RETRY_LIMIT, 16'd2);
        queue_start(1'b1, 8'h42, 8'h10, 8'd3);
        queue_tick();
        wait_drained();
        settings_used += 2;

        beat_target = 1250;
        plan = 0;
        while (beats_taken < beat_target) begin
            write_reg(CFG_RETRY_LIMIT, 16'(plan_retry[plan]));
            write_reg(CFG_WAIT_LIMIT, plan_wait[plan]);
            settings_used++;
            repeat (5) queue_transfer();
            wait_drained();
            plan = (plan + 1) % 7;
        end

        for (int n = 0; n < 200 && expected_results.size() != 0; n++) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_results.size());
            mismatches++;
        end
        $display("Run covered %0d input beats (%0d acted on) and %0d result beats over %0d limit settings.",
                 beats_taken, acted_beats, results_checked, settings_used);
        $display("Transfers: %0d succeeded, %0d failed; %0d bytes read, %0d bytes written.",
                 n_done_ok, n_failed, n_bytes_read, n_bytes_written);
        if (mismatches == 0) begin
            $display("tb_i2c_register_transfer_sequencer: clean");
        end else begin
            $display("tb_i2c_register_transfer_sequencer: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_i2c_register_transfer_sequencer: errors");
        $finish;
    end

endmodule
